FILE: sv/osm_pkg.sv
// Shared types and constants for the order statistic multiset.
// Request and status codes, controller states and the result handshake struct.
// No dependencies.
`default_nettype none

package osm_pkg;

	localparam int TYPE_BITS   = 3;
	localparam int STATUS_BITS = 2;
	localparam int CNT_BITS    = 11;

	typedef enum logic [TYPE_BITS-1:0] {
		OP_INSERT = 3'd0,
		OP_ERASE  = 3'd1,
		OP_KTH    = 3'd2,
		OP_CNT_LT = 3'd3,
		OP_CNT_LE = 3'd4,
		OP_SIZE   = 3'd5
	} osm_req_e;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} osm_status_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEARCH,
		S_EVAL,
		S_CHECK,
		S_SHIFT,
		S_PUT,
		S_KTH,
		S_DONE
	} osm_state_e;

	// result handshake between controller and output register
	typedef struct packed {
		logic        valid;
		osm_status_e status;
	} osm_res_t;

endpackage

`default_nettype wire

FILE: sv/osm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the sorted value store. No dependencies.
`default_nettype none

module osm_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/osm_ctrl.sv
// Controller of the order statistic multiset: binary search over the sorted
// store, shift on insert and erase, select by rank. Drives the RAM ports.
// Depends on osm_pkg.
`default_nettype none

module osm_ctrl #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 31
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output      logic                            req_ready,
	input  wire osm_pkg::osm_req_e               req_type,
	input  wire logic signed [VALUE_BITS-1:0]    key_value,
	input  wire logic [osm_pkg::CNT_BITS-1:0]    rank,
	output      osm_pkg::osm_res_t               res,
	input  wire logic                            out_free,
	output      logic signed [VALUE_BITS-1:0]    found_value,
	output      logic [osm_pkg::CNT_BITS-1:0]    rank_count,
	output      logic [osm_pkg::CNT_BITS-1:0]    held_count,
	output      logic                            ram_we,
	output      logic [$clog2(CAPACITY)-1:0]     ram_waddr,
	output      logic [VALUE_BITS-1:0]           ram_wdata,
	output      logic                            ram_re,
	output      logic [$clog2(CAPACITY)-1:0]     ram_raddr,
	input  wire logic [VALUE_BITS-1:0]           ram_rdata
);

	import osm_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = (CW > CNT_BITS) ? CW : CNT_BITS;

	osm_state_e                   state_q, state_d;
	osm_req_e                     op_q;
	logic signed [VALUE_BITS-1:0] key_q;
	logic [CNT_BITS-1:0]          rank_q;
	logic [CW-1:0]                held_q;
	logic [CW-1:0]                lo_q, hi_q, mid_q, rem_q, cnt_q;
	logic [AW-1:0]                r_q, waddr_s1;
	logic                         pend_s1;
	osm_status_e                  status_q;
	logic signed [VALUE_BITS-1:0] found_q;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic          le_mode, pred, full, kth_ok, hit, more, shift_end;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CW:1];
	assign le_mode   = (op_q == OP_INSERT) || (op_q == OP_CNT_LE);
	// insert places after equal keys; erase and count-less stop before them
	assign pred      = le_mode ? ($signed(ram_rdata) <= key_q) : ($signed(ram_rdata) < key_q);
	assign full      = (held_q == CW'(CAPACITY));
	assign kth_ok    = (rank_q != '0) && (KW'(rank_q) <= KW'(held_q));
	assign hit       = ($signed(ram_rdata) == key_q);
	assign more      = (lo_q < hi_q);
	assign shift_end = (rem_q == '0) && !pend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		res.valid  = 1'b0;
		res.status = status_q;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (op_q)
					OP_INSERT: state_d = full ? S_DONE : S_SEARCH;
					OP_ERASE, OP_CNT_LT, OP_CNT_LE: state_d = S_SEARCH;
					OP_KTH: begin
						if (kth_ok) begin
							ram_re    = 1'b1;
							ram_raddr = AW'(rank_q - 1'b1);
							state_d   = S_KTH;
						end else begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SEARCH: begin
				if (more) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(mid);
					state_d   = S_EVAL;
				end else begin
					case (op_q)
						OP_INSERT: state_d = S_SHIFT;
						OP_ERASE: begin
							if (lo_q < held_q) begin
								ram_re    = 1'b1;
								ram_raddr = AW'(lo_q);
								state_d   = S_CHECK;
							end else begin
								state_d = S_DONE;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_EVAL: state_d = S_SEARCH;
			S_CHECK: state_d = hit ? S_SHIFT : S_DONE;
			S_SHIFT: begin
				if (rem_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = r_q;
				end
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = waddr_s1;
					ram_wdata = ram_rdata;
				end
				if (shift_end) begin
					state_d = (op_q == OP_INSERT) ? S_PUT : S_DONE;
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(lo_q);
				ram_wdata = key_q;
				state_d   = S_DONE;
			end
			S_KTH: state_d = S_DONE;
			S_DONE: begin
				res.valid = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_SHIFT) && (rem_q != '0);
			if (state_q == S_PUT) begin
				held_q <= held_q + 1'b1;
			end else if (state_q == S_SHIFT && shift_end && op_q == OP_ERASE) begin
				held_q <= held_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_q     <= req_type;
					key_q    <= key_value;
					rank_q   <= rank;
					lo_q     <= '0;
					hi_q     <= held_q;
					status_q <= ST_OK;
					found_q  <= '0;
					cnt_q    <= '0;
				end
			end
			S_DISPATCH: begin
				if (op_q == OP_INSERT && full) begin
					status_q <= ST_FULL;
				end
				if (op_q == OP_KTH && !kth_ok) begin
					status_q <= ST_ABSENT;
				end
			end
			S_SEARCH: begin
				if (more) begin
					mid_q <= mid;
				end else begin
					if (op_q == OP_CNT_LT || op_q == OP_CNT_LE) begin
						cnt_q <= lo_q;
					end
					if (op_q == OP_INSERT) begin
						rem_q <= held_q - lo_q;
						r_q   <= AW'(held_q - 1'b1);
					end
					if (op_q == OP_ERASE && !(lo_q < held_q)) begin
						status_q <= ST_ABSENT;
					end
				end
			end
			S_EVAL: begin
				if (pred) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_CHECK: begin
				if (hit) begin
					rem_q <= held_q - lo_q - 1'b1;
					r_q   <= AW'(lo_q + 1'b1);
				end else begin
					status_q <= ST_ABSENT;
				end
			end
			S_SHIFT: begin
				// read one cell ahead, write it one place over in the next cycle
				if (rem_q != '0) begin
					waddr_s1 <= (op_q == OP_INSERT) ? r_q + 1'b1 : r_q - 1'b1;
					r_q      <= (op_q == OP_INSERT) ? r_q - 1'b1 : r_q + 1'b1;
					rem_q    <= rem_q - 1'b1;
				end
			end
			S_KTH: found_q <= $signed(ram_rdata);
			default: begin
			end
		endcase
	end

	assign found_value = found_q;
	assign rank_count  = CNT_BITS'(cnt_q);
	assign held_count  = CNT_BITS'(held_q);

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("held count above capacity");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SHIFT || state_q == S_PUT))
		else $error("store written outside shift or place");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("shift reads and writes the same cell");

	a_held_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (held_q == $past(held_q) || held_q == CW'($past(held_q) + 1'b1)
			|| held_q == CW'($past(held_q) - 1'b1)))
		else $error("held count moved by more than one");

	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> (held_q < CW'(CAPACITY)))
		else $error("insert placed into a full store");
`endif

endmodule

`default_nettype wire

FILE: sv/order_statistic_multiset.sv
// Top level of the order statistic multiset: stream ports, output register,
// sorted value store and its controller. Depends on osm_pkg, osm_ram, osm_ctrl.
//
//   channel   dir   tdata fields (low bit up)            tuser
//   s_*       in    key_value, rank, zero pad            req_type
//   m_*       out   found_value, rank_count, held_count,  status
//                   zero pad
//
// From the input transfer to the result register, a count request runs a
// binary search, one RAM read and one compare per search step. Insert and
// erase then move the cells above the found place, as the shift streams the
// single read port at one cell per cycle, and insert writes the new value into
// the freed cell; an erase first reads the found cell to check that the value
// is present. Select by rank reads one cell; size, full insert and bad rank
// go straight to the result. Requests are accepted only in the idle state.
// Reset clears the held count; store contents need no clearing pass, since
// only cells below the held count are ever read.
// The output register lets the next request start while a result waits for
// m_tready; a finished result holds in the controller until that register
// frees up.
`default_nettype none

module order_statistic_multiset #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 31
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         s_tvalid,
	output      logic                                         s_tready,
	// key_value, rank, zero pad
	input  wire logic [((VALUE_BITS + osm_pkg::CNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// req_type
	input  wire logic [osm_pkg::TYPE_BITS-1:0]                s_tuser,
	output      logic                                         m_tvalid,
	input  wire logic                                         m_tready,
	// found_value, rank_count, held_count, zero pad
	output      logic [((VALUE_BITS + 2 * osm_pkg::CNT_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// status
	output      logic [osm_pkg::STATUS_BITS-1:0]              m_tuser
);

	import osm_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	osm_res_t                     res;
	logic                         out_free;
	logic signed [VALUE_BITS-1:0] key_value, found_value;
	logic [CNT_BITS-1:0]          rank, rank_count, held_count;
	logic                         ram_we, ram_re;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [VALUE_BITS-1:0]        ram_wdata, ram_rdata;

	logic                         m_valid_q;
	osm_status_e                  status_q;
	logic signed [VALUE_BITS-1:0] found_q;
	logic [CNT_BITS-1:0]          count_q, held_q;

	// unpack the request
	assign key_value = $signed(s_tdata[VALUE_BITS-1:0]);
	assign rank      = s_tdata[VALUE_BITS +: CNT_BITS];

	// the output register can take a result when empty or being drained
	assign out_free = !m_valid_q || m_tready;

	osm_ctrl #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req_type   (osm_req_e'(s_tuser)),
		.key_value  (key_value),
		.rank       (rank),
		.res        (res),
		.out_free   (out_free),
		.found_value(found_value),
		.rank_count (rank_count),
		.held_count (held_count),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// sorted values, ascending, cells [0, held) valid
	osm_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// output register: load on a finished result, drop on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			status_q <= res.status;
			found_q  <= found_value;
			count_q  <= rank_count;
			held_q   <= held_count;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[VALUE_BITS-1:0]                   = found_q;
		m_tdata[VALUE_BITS +: CNT_BITS]            = count_q;
		m_tdata[VALUE_BITS + CNT_BITS +: CNT_BITS] = held_q;
	end

endmodule

`default_nettype wire
